// ----- hdl/polyphase_upfirdn_resampler_defines.svh -----
// Assertion macros shared by the resampler RTL.
`ifndef POLYPHASE_UPFIRDN_RESAMPLER_DEFINES_SVH
`define POLYPHASE_UPFIRDN_RESAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define UPFR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("upfr: assertion failed");
`define UPFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upfr: assertion failed");
`define UPFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upfr: assertion failed");
`else
`define UPFR_ASSERT(lbl, expr)
`define UPFR_ASSERT_IMP(lbl, ante, cons)
`define UPFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/upfr_pkg.sv -----
`default_nettype none
package upfr_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int RATE_W     = 5;
  localparam int TAPS_W     = 7;
  localparam int RESULT_W   = 40;
  localparam int PHASE_W    = 6;
  localparam int POS_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int QDEPTH     = 2;

  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_UP_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_LOAD,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } qcmd_t;

  typedef struct packed {
    logic [RATE_W-1:0] up_rate;
    logic [RATE_W-1:0] decim;
    logic [TAPS_W-1:0] tap_count;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/upfr_front.sv -----
`default_nettype none
module upfr_front #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [upfr_pkg::CMD_W-1:0]           cmd,
  input  wire logic [upfr_pkg::IDX_W-1:0]           coef_index,
  input  wire logic signed [SAMPLE_BITS-1:0]        data,
  output logic                                      q_valid,
  output upfr_pkg::qcmd_t                           q_cmd,
  output logic signed [SAMPLE_BITS-1:0]             q_data,
  input  wire logic                                 q_pop
);
  import upfr_pkg::*;

  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  qcmd_t                   q_mem [QDEPTH];
  logic signed [SAMPLE_BITS-1:0] d_mem [QDEPTH];
  logic [QPW-1:0]          wptr;
  logic [QPW-1:0]          rptr;
  logic [QCW-1:0]          count;
  logic                    keep;
  op_t                     op;
  logic                    push;

  // Unused commands and loads beyond the table are taken and dropped here.
  always_comb begin
    keep = 1'b0;
    op   = OP_SAMPLE;
    case (cmd)
      CMD_SAMPLE: begin
        keep = 1'b1;
        op   = OP_SAMPLE;
      end
      CMD_LOAD: begin
        keep = (32'(coef_index) < MAX_TAPS);
        op   = OP_LOAD;
      end
      CMD_RESTART: begin
        keep = 1'b1;
        op   = OP_RESTART;
      end
      default: begin
        keep = 1'b0;
        op   = OP_SAMPLE;
      end
    endcase
  end

  assign in_ready = (count != QCW'(QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_cmd    = q_mem[rptr];
  assign q_data   = d_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= '{op: op, idx: coef_index};
      d_mem[wptr] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == QPW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/upfr_back.sv -----
`default_nettype none
module upfr_back #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire upfr_pkg::cfg_t                         cfg,
  input  wire logic                                   q_valid,
  input  wire upfr_pkg::qcmd_t                        q_cmd,
  input  wire logic signed [SAMPLE_BITS-1:0]          q_data,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [upfr_pkg::RESULT_W-1:0]        result,
  output logic                                        last
);
  import upfr_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int FW = $clog2(MAX_TAPS + 1);

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           coef_vld;

  state_t                        state;
  state_t                        state_next;
  logic [PHASE_W-1:0]            phase;
  logic [PHASE_W-1:0]            nph;
  logic [PHASE_W-1:0]            up_ext;
  logic [PHASE_W-1:0]            ph_diff;
  logic [PHASE_W-1:0]            nph_diff;
  logic [POS_W-1:0]              pos;
  logic [FW-1:0]                 k;
  logic [FW-1:0]                 fill;
  logic [FW-1:0]                 fill_inc;
  logic [AW-1:0]                 wp;
  logic [AW-1:0]                 wp_inc;
  logic [AW-1:0]                 haddr;
  logic [AW-1:0]                 haddr_dec;
  logic [AW-1:0]                 caddr_w;
  logic [AW-1:0]                 caddr_r;

  logic signed [SAMPLE_BITS-1:0]   hist_rd;
  logic signed [SAMPLE_BITS-1:0]   coef_rd;
  logic signed [SAMPLE_BITS-1:0]   coef_eff;
  logic                            cvld_rd;
  logic signed [2*SAMPLE_BITS-1:0] mul;
  logic signed [RESULT_W-1:0]      prod;
  logic signed [RESULT_W-1:0]      acc;
  logic                            p1_v;
  logic                            p2_v;

  logic hist_we;
  logic coef_we;
  logic hist_clr;
  logic issue;
  logic emit;
  logic emit_last;
  logic out_free;
  logic first_out;

  assign up_ext    = PHASE_W'(cfg.up_rate);
  assign nph       = phase + PHASE_W'(cfg.decim);
  assign ph_diff   = phase - up_ext;
  assign nph_diff  = nph - up_ext;
  assign emit_last = (nph >= up_ext);
  assign out_free  = !out_valid || out_ready;
  assign first_out = (phase < up_ext);
  assign wp_inc    = (wp == AW'(MAX_TAPS - 1)) ? '0 : wp + 1'b1;
  assign fill_inc  = (fill == FW'(MAX_TAPS)) ? fill : fill + 1'b1;
  assign haddr_dec = (haddr == '0) ? AW'(MAX_TAPS - 1) : haddr - 1'b1;
  assign caddr_w   = AW'(q_cmd.idx);
  assign caddr_r   = AW'(pos);
  assign coef_eff  = cvld_rd ? coef_rd : '0;
  assign mul       = hist_rd * coef_eff;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_cmd.op == OP_SAMPLE && first_out) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (!issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v && !p2_v) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = emit_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    hist_we  = 1'b0;
    coef_we  = 1'b0;
    hist_clr = 1'b0;
    issue    = 1'b0;
    emit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_SAMPLE:  hist_we  = 1'b1;
            OP_LOAD:    coef_we  = 1'b1;
            OP_RESTART: hist_clr = 1'b1;
            default:    q_pop    = 1'b1;
          endcase
        end
      end
      ST_MAC: begin
        // Taps past the filled history hold zero, so the walk stops there too.
        issue = (pos < POS_W'(cfg.tap_count)) && (k < fill);
      end
      ST_EMIT: begin
        emit = out_free;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_inc] <= q_data;
    end
    hist_rd <= hist_mem[haddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[caddr_w] <= q_data;
    end
    coef_rd <= coef_mem[caddr_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      fill      <= '0;
      wp        <= '0;
      coef_vld  <= '0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      p1_v  <= issue;
      p2_v  <= p1_v;
      if (hist_we) begin
        wp   <= wp_inc;
        fill <= fill_inc;
        if (!first_out) begin
          phase <= {1'b0, ph_diff[RATE_W-1:0]};
        end
      end
      if (hist_clr) begin
        fill  <= '0;
        phase <= '0;
      end
      if (coef_we) begin
        coef_vld[caddr_w] <= 1'b1;
      end
      if (emit) begin
        phase <= emit_last ? {1'b0, nph_diff[RATE_W-1:0]} : nph;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cvld_rd <= coef_vld[caddr_r];
    prod    <= RESULT_W'(mul);
    if (hist_we) begin
      pos   <= POS_W'(phase);
      k     <= '0;
      haddr <= wp_inc;
      acc   <= '0;
    end else if (emit && !emit_last) begin
      pos   <= POS_W'(nph);
      k     <= '0;
      haddr <= wp;
      acc   <= '0;
    end else begin
      if (issue) begin
        pos   <= pos + POS_W'(cfg.up_rate);
        k     <= k + 1'b1;
        haddr <= haddr_dec;
      end
      if (p2_v) begin
        acc <= acc + prod;
      end
    end
    if (emit) begin
      result <= acc;
      last   <= emit_last;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/polyphase_upfirdn_resampler.sv -----
`default_nettype none
`include "polyphase_upfirdn_resampler_defines.svh"
// Rational polyphase resampler (up by up_rate, FIR, down by decim) for Q1.15 data with
// exact 40-bit Q.30 results. A two-entry command queue takes items at one per cycle while it
// has room and drops unused commands and out-of-range loads; a sequencer behind it runs one
// shared multiply-accumulate at one tap per cycle. A load or restart is taken straight from
// the queue. A sample writes history, then for each result it causes walks the taps of that
// phase that have history behind them, drains the pipeline and emits the result. The single
// MAC bounds throughput; the worst case is sixteen phases, no decimation and 64 taps. The
// output register lets the next result be computed while one waits. Coefficient validity
// is held in per-entry flags and history by a fill count, so reset needs no clearing pass.
// Write configuration only while idle.
module polyphase_upfirdn_resampler #(
  parameter int MAX_TAPS    = 64,
  parameter int MAX_RATE    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [upfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [upfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [upfr_pkg::CMD_W-1:0]           cmd,
  input  wire logic [upfr_pkg::IDX_W-1:0]           coef_index,
  input  wire logic signed [SAMPLE_BITS-1:0]        data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [upfr_pkg::RESULT_W-1:0]      result,
  output logic                                      last
);
  import upfr_pkg::*;

  logic [RATE_W-1:0]             up_rate;
  logic [RATE_W-1:0]             decim;
  logic [TAPS_W-1:0]             tap_count;
  cfg_t                          cfg;
  logic                          q_valid;
  qcmd_t                         q_cmd;
  logic signed [SAMPLE_BITS-1:0] q_data;
  logic                          q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_rate   <= RATE_W'(1);
      decim     <= RATE_W'(1);
      tap_count <= TAPS_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_RATE:   up_rate   <= cfg_data[RATE_W-1:0];
        REG_DECIM:     decim     <= cfg_data[RATE_W-1:0];
        REG_TAP_COUNT: tap_count <= cfg_data[TAPS_W-1:0];
        default:       tap_count <= tap_count;
      endcase
    end
  end

  // A zero rate acts as one; rates and tap count saturate at the built-in limits.
  always_comb begin
    if (up_rate == '0) begin
      cfg.up_rate = RATE_W'(1);
    end else if (32'(up_rate) > MAX_RATE) begin
      cfg.up_rate = RATE_W'(MAX_RATE);
    end else begin
      cfg.up_rate = up_rate;
    end
    if (decim == '0) begin
      cfg.decim = RATE_W'(1);
    end else if (32'(decim) > MAX_RATE) begin
      cfg.decim = RATE_W'(MAX_RATE);
    end else begin
      cfg.decim = decim;
    end
    if (32'(tap_count) > MAX_TAPS) begin
      cfg.tap_count = TAPS_W'(MAX_TAPS);
    end else begin
      cfg.tap_count = tap_count;
    end
  end

  upfr_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .coef_index (coef_index),
    .data       (data),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  upfr_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .last      (last)
  );

  `UPFR_ASSERT(a_full_holds_entry, in_ready || q_valid)
  `UPFR_ASSERT_IMP(a_pop_needs_entry, q_pop, q_valid)
  `UPFR_ASSERT_NXT(a_pop_frees_slot, q_pop && !in_ready, in_ready)
  `UPFR_ASSERT(a_rates_nonzero, cfg.up_rate != '0 && cfg.decim != '0)

endmodule
`default_nettype wire

// ----- sim/polyphase_upfirdn_resampler_tb.sv -----
module polyphase_upfirdn_resampler_tb;
  import upfr_pkg::*;

  localparam int TAPS = 64;
  localparam int RATE_MAX = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic signed [RESULT_W-1:0] result;
    logic last;
  } out_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [IDX_W-1:0] coef_index = '0;
  logic signed [15:0] data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RESULT_W-1:0] result;
  logic last;

  // Shadow state of the resampler.
  logic signed [15:0] hist_shadow [TAPS];
  logic signed [15:0] coef_shadow [TAPS];
  int unsigned phase_shadow;
  logic [RATE_W-1:0] up_shadow;
  logic [RATE_W-1:0] down_shadow;
  logic [TAPS_W-1:0] taps_shadow;

  out_item_t expected_out[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int unsigned hold_req = 0;

  polyphase_upfirdn_resampler u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .coef_index(coef_index),
    .data      (data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int unsigned eff_rate(input logic [RATE_W-1:0] r);
    if (r == 0) return 1;
    if (r > RATE_MAX) return RATE_MAX;
    return r;
  endfunction

  // Applies one input transaction to the shadow state and queues the outputs it causes.
  function automatic void resample_step(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                                        input logic signed [15:0] d);
    int unsigned up;
    int unsigned down;
    int unsigned ntaps;
    int unsigned pos;
    int unsigned k;
    longint acc;
    out_item_t pend;
    bit have_pend;
    have_pend = 1'b0;
    case (c)
      CMD_LOAD: coef_shadow[idx] = d;
      CMD_RESTART: begin
        foreach (hist_shadow[i]) hist_shadow[i] = '0;
        phase_shadow = 0;
      end
      CMD_SAMPLE: begin
        up = eff_rate(up_shadow);
        down = eff_rate(down_shadow);
        ntaps = (taps_shadow > TAPS) ? TAPS : taps_shadow;
        for (int i = TAPS - 1; i > 0; i--) hist_shadow[i] = hist_shadow[i-1];
        hist_shadow[0] = d;
        while (phase_shadow < up) begin
          acc = 0;
          pos = phase_shadow;
          k = 0;
          while (pos < ntaps && k < TAPS) begin
            acc += longint'(coef_shadow[pos]) * longint'(hist_shadow[k]);
            pos += up;
            k++;
          end
          if (have_pend) expected_out.push_back(pend);
          pend.result = acc[RESULT_W-1:0];
          pend.last = 1'b0;
          have_pend = 1'b1;
          phase_shadow += down;
        end
        if (have_pend) begin
          pend.last = 1'b1;
          expected_out.push_back(pend);
        end
        phase_shadow = (phase_shadow - up) & 32'h1F;
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_q15();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(1, RATE_MAX));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_taps();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom);
      1: return CFG_DATA_W'(TAPS);
      default: return CFG_DATA_W'($urandom_range(1, TAPS));
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted,
  // leaving in_valid high so back-to-back items need no extra edge.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                           input logic signed [15:0] d);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    coef_index <= idx;
    data <= d;
    do @(posedge clk); while (!in_ready);
    resample_step(c, idx, d);
  endtask

  // Loads, restarts and result-free samples may still be in flight after the last
  // output, so allow a short settling time before touching the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] up, input logic [CFG_DATA_W-1:0] down,
                                input logic [CFG_DATA_W-1:0] ntaps);
    cfg_we <= 1'b1;
    cfg_index <= REG_UP_RATE;
    cfg_data <= up;
    @(posedge clk);
    cfg_index <= REG_DECIM;
    cfg_data <= down;
    @(posedge clk);
    cfg_index <= REG_TAP_COUNT;
    cfg_data <= ntaps;
    @(posedge clk);
    cfg_we <= 1'b0;
    up_shadow = up[RATE_W-1:0];
    down_shadow = down[RATE_W-1:0];
    taps_shadow = ntaps[TAPS_W-1:0];
  endtask

  task automatic test_reset_state();
    send_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
    send_item(CMD_UNUSED, 6'd63, 16'sh8000);
  endtask

  task automatic test_coef_extremes();
    send_item(CMD_LOAD, 6'd0, 16'sh8000);
    send_item(CMD_LOAD, 6'd63, 16'sh7FFF);
    send_item(CMD_LOAD, 6'd1, 16'sh7FFF);
    send_item(CMD_SAMPLE, 6'd63, 16'sh8000);
    send_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
    send_item(CMD_SAMPLE, 6'd21, 16'sh0000);
    send_item(CMD_SAMPLE, 6'd42, 16'sh8000);
  endtask

  task automatic test_restart();
    send_item(CMD_RESTART, 6'd0, 16'sh7FFF);
    send_item(CMD_SAMPLE, 6'd0, 16'sh8000);
  endtask

  task automatic test_rate_extremes();
    // Zero rates through masked upper bits, and no taps at all.
    wait_idle();
    apply_settings(7'h20, 7'h40, 7'd0);
    send_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
    // Up rate and tap count above their ranges.
    wait_idle();
    apply_settings(7'h7F, 7'd1, 7'h7F);
    send_item(CMD_SAMPLE, 6'd0, 16'sh8000);
    // Decimation beyond interpolation skips samples.
    wait_idle();
    apply_settings(7'd1, 7'd16, 7'd64);
    repeat (3) send_item(CMD_SAMPLE, 6'd0, rand_q15());
  endtask

  task automatic test_output_stall();
    wait_idle();
    apply_settings(7'd16, 7'd1, 7'd64);
    hold_req = 300;
    repeat (10) send_item(CMD_SAMPLE, 6'($urandom), rand_q15());
  endtask

  task automatic run_stream_round(input int n_samples, input bit with_restart);
    int r;
    wait_idle();
    apply_settings(pick_rate(), pick_rate(), pick_taps());
    if (with_restart) send_item(CMD_RESTART, 6'($urandom), rand_q15());
    repeat ($urandom_range(4, 12)) send_item(CMD_LOAD, 6'($urandom), rand_q15());
    repeat (n_samples) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_item(CMD_UNUSED, 6'($urandom), rand_q15());
      else if (r == 1) send_item(CMD_LOAD, 6'($urandom), rand_q15());
      else if (r == 2) send_item(CMD_RESTART, 6'($urandom), rand_q15());
      else send_item(CMD_SAMPLE, 6'($urandom), rand_q15());
    end
  endtask

  task automatic test_random_stream();
    // Some rounds keep the phase from the previous setting to cover rate changes mid-stream.
    repeat (5) run_stream_round(35, $urandom_range(0, 2) != 0);
  endtask

  task automatic test_quiet_stream();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    run_stream_round(35, 1'b0);
  endtask

  always @(posedge clk) begin : sink_ctl
    int unsigned stall_left;
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding", result));
      end else begin
        want = expected_out.pop_front();
        if (result !== want.result)
          report_mismatch($sformatf("result got %0d want %0d", result, want.result));
        if (last !== want.last)
          report_mismatch($sformatf("last got %b want %b", last, want.last));
      end
    end
  end

  initial begin
    foreach (hist_shadow[i]) hist_shadow[i] = '0;
    foreach (coef_shadow[i]) coef_shadow[i] = '0;
    phase_shadow = 0;
    up_shadow = 5'd1;
    down_shadow = 5'd1;
    taps_shadow = 7'd64;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_coef_extremes();
    test_restart();
    test_rate_extremes();
    test_output_stall();
    test_random_stream();
    test_quiet_stream();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_out.size() != 0) report_mismatch("results still outstanding at the end");
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
